>>> sv/crtc_pkg.sv
// shared types, register map and helpers for the rtc register file
package crtc_pkg;

  // request type codes
  localparam logic [1:0] ReqRead  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  // i/o port addresses
  localparam logic [15:0] PortIndex = 16'h0070;
  localparam logic [15:0] PortData  = 16'h0071;
  localparam logic [15:0] PortExt   = 16'h003F;

  // register map
  localparam logic [6:0] RegSec     = 7'h00;
  localparam logic [6:0] RegMin     = 7'h02;
  localparam logic [6:0] RegHour    = 7'h04;
  localparam logic [6:0] RegWday    = 7'h06;
  localparam logic [6:0] RegDay     = 7'h07;
  localparam logic [6:0] RegMon     = 7'h08;
  localparam logic [6:0] RegYear    = 7'h09;
  localparam logic [6:0] RegA       = 7'h0A;
  localparam logic [6:0] RegB       = 7'h0B;
  localparam logic [6:0] RegC       = 7'h0C;
  localparam logic [6:0] RegD       = 7'h0D;
  localparam logic [6:0] RegExtAddr = 7'h3D;
  localparam logic [6:0] RegExtData = 7'h3F;

  // data constants
  localparam logic [7:0] IrqFlags = 8'hC0;
  localparam logic [7:0] ValidRam = 8'h80;
  localparam logic [7:0] IdleByte = 8'hFF;
  localparam logic [6:0] IndexMask = 7'h7F;
  localparam logic [3:0] RateMask  = 4'hF;

  // one access to a store
  typedef struct packed {
    logic       re;
    logic       we;
    logic [6:0] addr;
    logic [7:0] wdata;
  } crtc_req_t;

  // bcd of a value below 100, tens by reciprocal multiply
  function automatic logic [7:0] crtc_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> sv/crtc_ram.sv
// generic single-port ram with registered read
module crtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/crtc_store.sv
// byte store cleared at reset: ram plus per-entry valid bits
module crtc_store
  import crtc_pkg::*;
#(
  parameter int STORE_DEPTH = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  crtc_req_t req_i,
  output logic [7:0] rdata_o
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [STORE_DEPTH-1:0] valid_q;
  logic                   rvalid_q;
  logic [7:0]             ram_rdata;
  logic [AW-1:0]          addr;

  assign addr = req_i.addr[AW-1:0];

  crtc_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (req_i.re | req_i.we),
    .we_i   (req_i.we),
    .addr_i (addr),
    .wdata_i(req_i.wdata),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[addr];
      end
    end
  end

  // never-written entries read as their reset value
  assign rdata_o = rvalid_q ? ram_rdata : 8'h00;

endmodule

>>> sv/cmos_rtc_register_file_unit.sv
// rtc cmos register file top level: access sequencer around two byte stores
// Each item raised on start while busy is low produces exactly one result beat on
// result_valid_o, one cycle wide; the receiver cannot hold it off. Index writes,
// data and extended writes, unmapped accesses and unknown request types leave
// busy low, with the result in the following cycle. A mapped data-port read
// passes through the read state, because the main store ram has a registered
// read. A tick is accepted and then works through the tick steps, because the main
// store has one write port and the interrupt flags plus seven time registers are
// written one per cycle. Both stores come out of reset all zero with no clearing
// pass.
module cmos_rtc_register_file_unit
  import crtc_pkg::*;
#(
  parameter int STORE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] port_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [5:0]  now_seconds_i,
  input  logic [5:0]  now_minutes_i,
  input  logic [4:0]  now_hours_i,
  input  logic [2:0]  now_weekday_i,
  input  logic [4:0]  now_day_i,
  input  logic [3:0]  now_month_i,
  input  logic [13:0] now_year_i,
  input  logic [9:0]  now_millis_i,
  output logic        result_valid_o,
  output logic [7:0]  read_data_o,
  output logic        irq_pulse_o,
  output logic        rate_changed_o,
  output logic [3:0]  rate_select_o
);

  localparam logic [7:0] DepthLim = 8'(STORE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StTick
  } state_e;

  state_e      state_q;
  logic [2:0]  step_q;
  logic [6:0]  reg_index_q;
  logic [3:0]  rate_q;
  logic [1:0]  b_flags_q;   // register b bits 7 and 6
  logic [6:0]  ext_addr_q;  // register 0x3d masked
  logic        valid_q;
  logic [7:0]  rdata_q;
  logic        irq_q;
  logic        rchg_q;

  // tick payload
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [2:0]  wday_q;
  logic [4:0]  day_q;
  logic [3:0]  mon_q;
  logic [13:0] year_q;
  logic [7:0]  yquot_q;
  logic [6:0]  yrem_q;
  logic        uip_q;
  logic        irq_en_q;
  logic        set_q;

  crtc_req_t   main_req;
  crtc_req_t   ext_req;
  logic [7:0]  main_rdata;
  logic [7:0]  ext_rdata;

  logic        accept;
  logic        idx_ok;
  logic        ext_ok;
  logic        is_data;
  logic        is_read;
  logic        is_write;
  logic [6:0]  tick_addr;
  logic [7:0]  tick_data;
  logic [7:0]  read_byte;
  logic [27:0] yprod;

  assign accept   = start && (state_q == StIdle);
  assign idx_ok   = {1'b0, reg_index_q} < DepthLim;
  assign ext_ok   = {1'b0, ext_addr_q} < DepthLim;
  assign is_data  = port_addr_i == PortData;
  assign is_read  = req_type_i == ReqRead;
  assign is_write = req_type_i == ReqWrite;
  assign yprod    = 28'(year_q) * 28'd10486;

  // time register for each tick step
  always_comb begin
    tick_addr = RegSec;
    tick_data = 8'h00;
    case (step_q)
      3'd1: begin tick_addr = RegSec;  tick_data = crtc_bcd(7'(sec_q));  end
      3'd2: begin tick_addr = RegMin;  tick_data = crtc_bcd(7'(min_q));  end
      3'd3: begin tick_addr = RegHour; tick_data = crtc_bcd(7'(hour_q)); end
      3'd4: begin tick_addr = RegWday; tick_data = crtc_bcd(7'(wday_q)); end
      3'd5: begin tick_addr = RegDay;  tick_data = crtc_bcd(7'(day_q));  end
      3'd6: begin tick_addr = RegMon;  tick_data = crtc_bcd(7'(mon_q));  end
      3'd7: begin tick_addr = RegYear; tick_data = crtc_bcd(yrem_q);     end
      default: begin tick_addr = RegSec; tick_data = 8'h00; end
    endcase
  end

  // byte returned by a mapped data-port read
  always_comb begin
    case (reg_index_q)
      RegA:       read_byte = {uip_q, main_rdata[6:0]};
      RegD:       read_byte = (main_rdata == 8'h00) ? ValidRam : main_rdata;
      RegExtData: read_byte = ext_ok ? ext_rdata : IdleByte;
      default:    read_byte = main_rdata;
    endcase
  end

  // store access muxing
  always_comb begin
    main_req = '0;
    ext_req  = '0;
    unique case (state_q)
      StIdle: begin
        if (accept && is_data && idx_ok) begin
          main_req.addr  = reg_index_q;
          main_req.wdata = write_data_i;
          main_req.we    = is_write;
          main_req.re    = is_read;
        end
        if (accept && ext_ok) begin
          ext_req.addr  = ext_addr_q;
          ext_req.wdata = write_data_i;
          ext_req.we    = is_write && (port_addr_i == PortExt);
          ext_req.re    = is_read && is_data && idx_ok && (reg_index_q == RegExtData);
        end
      end
      StRead: begin
        if (reg_index_q == RegC) begin
          main_req.we    = 1'b1;
          main_req.addr  = RegC;
          main_req.wdata = 8'h00;
        end else if (reg_index_q == RegD && main_rdata == 8'h00) begin
          main_req.we    = 1'b1;
          main_req.addr  = RegD;
          main_req.wdata = ValidRam;
        end
      end
      StTick: begin
        if (step_q == 3'd0) begin
          main_req.we    = irq_en_q;
          main_req.addr  = RegC;
          main_req.wdata = IrqFlags;
        end else begin
          main_req.we    = !set_q;
          main_req.addr  = tick_addr;
          main_req.wdata = tick_data;
        end
      end
      default: begin
        main_req = '0;
        ext_req  = '0;
      end
    endcase
  end

  crtc_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_main (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (main_req),
    .rdata_o(main_rdata)
  );

  crtc_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ext (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ext_req),
    .rdata_o(ext_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= 3'd0;
      reg_index_q <= 7'h00;
      rate_q      <= 4'h0;
      b_flags_q   <= 2'b00;
      ext_addr_q  <= 7'h00;
      valid_q     <= 1'b0;
      rdata_q     <= IdleByte;
      irq_q       <= 1'b0;
      rchg_q      <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          // items that leave busy low answer right away, reads and ticks answer later
          valid_q <= accept && (req_type_i != ReqTick) && !(is_read && is_data && idx_ok);
          if (accept) begin
            rdata_q <= IdleByte;
            irq_q   <= 1'b0;
            rchg_q  <= is_write && is_data && idx_ok && (reg_index_q == RegA);
            if (req_type_i == ReqTick) begin
              state_q <= StTick;
              step_q  <= 3'd0;
            end else if (is_read && is_data && idx_ok) begin
              state_q <= StRead;
            end else begin
              if (is_write && port_addr_i == PortIndex) begin
                reg_index_q <= write_data_i[6:0] & IndexMask;
              end
              // shadows of the registers the sequencer needs without a read
              if (is_write && is_data && idx_ok) begin
                if (reg_index_q == RegA) begin
                  rate_q <= write_data_i[3:0] & RateMask;
                end
                if (reg_index_q == RegB) begin
                  b_flags_q <= write_data_i[7:6];
                end
                if (reg_index_q == RegExtAddr) begin
                  ext_addr_q <= write_data_i[6:0] & IndexMask;
                end
              end
            end
          end
        end
        StRead: begin
          valid_q <= 1'b1;
          rdata_q <= read_byte;
          state_q <= StIdle;
        end
        StTick: begin
          step_q  <= step_q + 3'd1;
          valid_q <= step_q == 3'd7;
          if (step_q == 3'd7) begin
            irq_q   <= irq_en_q;
            state_q <= StIdle;
          end
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= StIdle;
        end
      endcase
    end
  end

  // item payload and year mod 100, worked over the first tick steps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sec_q    <= now_seconds_i;
      min_q    <= now_minutes_i;
      hour_q   <= now_hours_i;
      wday_q   <= now_weekday_i;
      day_q    <= now_day_i;
      mon_q    <= now_month_i;
      year_q   <= now_year_i;
      uip_q    <= now_millis_i < 10'd10;
      irq_en_q <= b_flags_q[0];
      set_q    <= b_flags_q[1];
    end
    if (state_q == StTick && step_q == 3'd0) begin
      yquot_q <= yprod[27:20];
    end
    if (state_q == StTick && step_q == 3'd1) begin
      yrem_q <= 7'(year_q - 14'(yquot_q) * 14'd100);
    end
  end

  assign busy           = state_q != StIdle;
  assign result_valid_o = valid_q;
  assign read_data_o    = rdata_q;
  assign irq_pulse_o    = irq_q;
  assign rate_changed_o = rchg_q;
  assign rate_select_o  = rate_q;

endmodule

>>> tb/sv/crtc_result_checker.sv
// checker for the rtc register file: tracks the register state, predicts each beat, compares
`timescale 1ns / 1ps

module crtc_result_checker
  import crtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] port_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [5:0]  now_seconds_i,
  input  logic [5:0]  now_minutes_i,
  input  logic [4:0]  now_hours_i,
  input  logic [2:0]  now_weekday_i,
  input  logic [4:0]  now_day_i,
  input  logic [3:0]  now_month_i,
  input  logic [13:0] now_year_i,
  input  logic [9:0]  now_millis_i,
  input  logic        res_valid_i,
  input  logic [7:0]  read_data_i,
  input  logic        irq_pulse_i,
  input  logic        rate_changed_i,
  input  logic [3:0]  rate_select_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
    logic       rchg;
    logic [3:0] rate;
  } reply_t;

  logic [6:0] sel_index;
  logic [7:0] main_mem [128];
  logic [7:0] ext_mem  [128];
  reply_t     owed_replies [$];
  reply_t     want;
  reply_t     got;
  int         mismatches;
  int         compared;

  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // applies one access to the tracked registers and returns the beat it should produce
  function automatic reply_t apply_access(
    input logic [1:0]  req,
    input logic [15:0] port,
    input logic [7:0]  wdata,
    input logic [5:0]  sec,
    input logic [5:0]  mins,
    input logic [4:0]  hr,
    input logic [2:0]  wday,
    input logic [4:0]  day,
    input logic [3:0]  mon,
    input logic [13:0] yr,
    input logic [9:0]  ms
  );
    reply_t     r;
    logic [7:0] breg;
    r.rd   = IdleByte;
    r.irq  = 1'b0;
    r.rchg = 1'b0;
    case (req)
      ReqTick: begin
        breg = main_mem[RegB];
        if (breg[6]) begin
          main_mem[RegC] = IrqFlags;
          r.irq = 1'b1;
        end
        // set bit freezes the time registers
        if (!breg[7]) begin
          main_mem[RegSec]  = to_bcd(sec);
          main_mem[RegMin]  = to_bcd(mins);
          main_mem[RegHour] = to_bcd(hr);
          main_mem[RegWday] = to_bcd(wday);
          main_mem[RegDay]  = to_bcd(day);
          main_mem[RegMon]  = to_bcd(mon);
          main_mem[RegYear] = to_bcd(int'(yr) % 100);
        end
      end
      ReqRead: begin
        if (port == PortData) begin
          r.rd = main_mem[sel_index];
          if (sel_index == RegC) begin
            main_mem[RegC] = 8'h00;
          end else if (sel_index == RegA) begin
            r.rd = {ms < 10'd10, r.rd[6:0]};
          end else if (sel_index == RegD) begin
            if (r.rd == 8'h00) begin
              main_mem[RegD] = ValidRam;
              r.rd = ValidRam;
            end
          end else if (sel_index == RegExtData) begin
            r.rd = ext_mem[main_mem[RegExtAddr][6:0]];
          end
        end
      end
      ReqWrite: begin
        if (port == PortExt) begin
          ext_mem[main_mem[RegExtAddr][6:0]] = wdata;
        end else if (port == PortIndex) begin
          sel_index = wdata[6:0];
        end else if (port == PortData) begin
          main_mem[sel_index] = wdata;
          if (sel_index == RegA) r.rchg = 1'b1;
        end
      end
      default: ;
    endcase
    r.rate = main_mem[RegA][3:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_index = '0;
      foreach (main_mem[i]) main_mem[i] = '0;
      foreach (ext_mem[i]) ext_mem[i] = '0;
      owed_replies.delete();
      mismatches = 0;
      compared = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // the result of an item never shows up on the edge that accepts it
      if (res_valid_i) begin
        got = {read_data_i, irq_pulse_i, rate_changed_i, rate_select_i};
        if (owed_replies.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: rd=%02h irq=%0d chg=%0d rate=%0h",
                     got.rd, got.irq, got.rchg, got.rate);
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          compared++;
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: expected rd=%02h irq=%0d chg=%0d rate=%0h, got rd=%02h irq=%0d chg=%0d rate=%0h",
                       want.rd, want.irq, want.rchg, want.rate,
                       got.rd, got.irq, got.rchg, got.rate);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i)
        owed_replies.push_back(apply_access(req_type_i, port_addr_i, write_data_i,
                                            now_seconds_i, now_minutes_i, now_hours_i,
                                            now_weekday_i, now_day_i, now_month_i,
                                            now_year_i, now_millis_i));
      fail_count_o <= mismatches;
      pending_o <= owed_replies.size();
      checked_o <= compared;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the rtc register file: clock, reset, access stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import crtc_pkg::*;

  localparam int CycleLimit = 200000;
  // request code the block does not define
  localparam logic [1:0] ReqUndef = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [15:0] port_addr = '0;
  logic [7:0]  write_data = '0;
  logic [5:0]  now_seconds = '0;
  logic [5:0]  now_minutes = '0;
  logic [4:0]  now_hours = '0;
  logic [2:0]  now_weekday = '0;
  logic [4:0]  now_day = '0;
  logic [3:0]  now_month = '0;
  logic [13:0] now_year = '0;
  logic [9:0]  now_millis = '0;
  logic        result_valid;
  logic [7:0]  read_data;
  logic        irq_pulse;
  logic        rate_changed;
  logic [3:0]  rate_select;

  int fail_count;
  int pending;
  int checked;

  // wall-clock values carried by the next beat
  logic [5:0]  t_sec;
  logic [5:0]  t_min;
  logic [4:0]  t_hr;
  logic [2:0]  t_wday;
  logic [4:0]  t_day;
  logic [3:0]  t_mon;
  logic [13:0] t_yr;
  logic [9:0]  t_ms;

  int gap_pct;
  int sent;
  int n_reads;
  int n_writes;
  int n_ticks;
  int n_other;
  int cycles;
  int total_fail;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cmos_rtc_register_file_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .port_addr_i    (port_addr),
    .write_data_i   (write_data),
    .now_seconds_i  (now_seconds),
    .now_minutes_i  (now_minutes),
    .now_hours_i    (now_hours),
    .now_weekday_i  (now_weekday),
    .now_day_i      (now_day),
    .now_month_i    (now_month),
    .now_year_i     (now_year),
    .now_millis_i   (now_millis),
    .result_valid_o (result_valid),
    .read_data_o    (read_data),
    .irq_pulse_o    (irq_pulse),
    .rate_changed_o (rate_changed),
    .rate_select_o  (rate_select)
  );

  crtc_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_type_i     (req_type),
    .port_addr_i    (port_addr),
    .write_data_i   (write_data),
    .now_seconds_i  (now_seconds),
    .now_minutes_i  (now_minutes),
    .now_hours_i    (now_hours),
    .now_weekday_i  (now_weekday),
    .now_day_i      (now_day),
    .now_month_i    (now_month),
    .now_year_i     (now_year),
    .now_millis_i   (now_millis),
    .res_valid_i    (result_valid),
    .read_data_i    (read_data),
    .irq_pulse_i    (irq_pulse),
    .rate_changed_i (rate_changed),
    .rate_select_i  (rate_select),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // drive one beat and hold it until the block takes it
  task automatic issue(input logic [1:0] req, input logic [15:0] port, input logic [7:0] data);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start       <= 1'b1;
    req_type    <= req;
    port_addr   <= port;
    write_data  <= data;
    now_seconds <= t_sec;
    now_minutes <= t_min;
    now_hours   <= t_hr;
    now_weekday <= t_wday;
    now_day     <= t_day;
    now_month   <= t_mon;
    now_year    <= t_yr;
    now_millis  <= t_ms;
    do @(posedge clk_i); while (busy);
    sent++;
    case (req)
      ReqRead:  n_reads++;
      ReqWrite: n_writes++;
      ReqTick:  n_ticks++;
      default:  n_other++;
    endcase
  endtask

  // index write with a random top bit, then a data-port access
  task automatic reg_read(input logic [6:0] idx);
    issue(ReqWrite, PortIndex, {1'($urandom_range(1)), idx});
    issue(ReqRead, PortData, 8'($urandom_range(255)));
  endtask

  task automatic reg_write(input logic [6:0] idx, input logic [7:0] val);
    issue(ReqWrite, PortIndex, {1'($urandom_range(1)), idx});
    issue(ReqWrite, PortData, val);
  endtask

  // stop sending until every owed beat is back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic roll_time();
    if ($urandom_range(19) == 0) begin
      // full field width, beyond the calendar ranges
      t_sec  = 6'($urandom_range(63));
      t_min  = 6'($urandom_range(63));
      t_hr   = 5'($urandom_range(31));
      t_wday = 3'($urandom_range(7));
      t_day  = 5'($urandom_range(31));
      t_mon  = 4'($urandom_range(15));
      t_yr   = 14'($urandom_range(16383));
    end else begin
      t_sec  = 6'($urandom_range(59));
      t_min  = 6'($urandom_range(59));
      t_hr   = 5'($urandom_range(23));
      t_wday = 3'($urandom_range(6));
      t_day  = 5'($urandom_range(31, 1));
      t_mon  = 4'($urandom_range(12, 1));
      t_yr   = 14'($urandom_range(9999));
    end
    t_ms = ($urandom_range(99) < 30) ? 10'($urandom_range(9)) : 10'($urandom_range(999));
  endtask

  function automatic logic [6:0] pick_reg();
    case ($urandom_range(11))
      0: return RegA;
      1: return RegB;
      2: return RegC;
      3: return RegD;
      4: return RegExtAddr;
      5: return RegExtData;
      6: return RegSec;
      7: return RegYear;
      8: return RegMon;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [15:0] noise_port();
    case ($urandom_range(5))
      0: return PortIndex;
      1: return PortData;
      2: return PortExt;
      3: return 16'(PortData ^ (16'd1 << $urandom_range(15)));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_phase(input int pct, input int count);
    int stop_at;
    int pick;
    stop_at = sent + count;
    gap_pct = pct;
    while (sent < stop_at) begin
      roll_time();
      pick = $urandom_range(99);
      if (pick < 25) begin
        reg_read(pick_reg());
      end else if (pick < 45) begin
        reg_write(pick_reg(), 8'($urandom_range(255)));
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 3)) begin
          roll_time();
          issue(ReqTick, 16'($urandom_range(65535)), 8'($urandom_range(255)));
        end
        reg_read(7'($urandom_range(9)));
      end else if (pick < 70) begin
        reg_write(RegB, 8'($urandom_range(255)));
      end else if (pick < 80) begin
        // extended bank: point the address register, store a byte, read it back
        reg_write(RegExtAddr, 8'($urandom_range(255)));
        issue(ReqWrite, PortExt, 8'($urandom_range(255)));
        reg_read(RegExtData);
      end else if (pick < 87) begin
        reg_write(RegA, 8'($urandom_range(255)));
        reg_read(RegA);
      end else begin
        issue(($urandom_range(9) == 0) ? ReqUndef : 2'($urandom_range(1)), noise_port(),
              8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    gap_pct = 9;
    roll_time();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed beats
    issue(ReqRead, PortData, 8'h00);
    reg_read(RegD);
    issue(ReqRead, PortData, 8'h00);
    t_sec = 6'd59; t_min = 6'd59; t_hr = 5'd23; t_wday = 3'd6;
    t_day = 5'd31; t_mon = 4'd12; t_yr = 14'd9999; t_ms = 10'd0;
    issue(ReqTick, PortData, 8'h00);
    reg_read(RegYear);
    t_sec = 6'd0; t_min = 6'd0; t_hr = 5'd0; t_wday = 3'd0;
    t_day = 5'd1; t_mon = 4'd1; t_yr = 14'd0; t_ms = 10'd999;
    issue(ReqTick, 16'hFFFF, 8'hFF);
    reg_read(RegSec);
    reg_write(RegA, 8'hFF);
    t_ms = 10'd9;
    reg_read(RegA);
    reg_write(RegB, 8'hC0);
    issue(ReqTick, PortIndex, 8'h00);
    reg_read(RegC);
    issue(ReqRead, PortData, 8'h00);
    reg_write(RegExtAddr, 8'h7F);
    issue(ReqWrite, PortExt, 8'hA5);
    reg_read(RegExtData);
    issue(ReqRead, PortExt, 8'h00);
    issue(ReqUndef, PortData, 8'hFF);
    issue(ReqWrite, 16'hFFFF, 8'h5A);
    settle();

    random_phase(9, 360);
    settle();
    random_phase(52, 360);
    settle();
    random_phase(0, 360);
    settle();

    repeat (20) @(posedge clk_i);
    total_fail = fail_count + pending;
    $display("sent %0d beats: %0d reads, %0d writes, %0d ticks, %0d undefined requests",
             sent, n_reads, n_writes, n_ticks, n_other);
    $display("compared %0d result beats over three pacing phases, %0d failures",
             checked, total_fail);
    if (total_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/crtc_pkg.sv
sv/crtc_ram.sv
sv/crtc_store.sv
sv/cmos_rtc_register_file_unit.sv
tb/sv/crtc_result_checker.sv
tb/sv/tb_top.sv
